// ----- rtl/core/mtp_pkg.sv -----
// Shared types, constants and word functions for the MT19937 generator.
package mtp_pkg;

    localparam int StateWords = 624;
    localparam int FarTap     = 397;
    localparam int CntW       = 10;

    typedef logic [31:0]     word_t;
    typedef logic [CntW-1:0] cnt_t;

    localparam word_t SeedReset  = 32'd5489;
    localparam word_t Matrix     = 32'h9908_b0df;
    localparam word_t UpperMask  = 32'h8000_0000;
    localparam word_t LowerMask  = 32'h7fff_ffff;
    localparam word_t InitMult   = 32'd1812433253;
    localparam word_t TemperB    = 32'd2636928640;
    localparam word_t TemperC    = 32'd4022730752;
    localparam cnt_t  SeedLast   = cnt_t'(StateWords - 1);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SEED,
        ST_DRAW
    } mtp_state_t;

    // Fixed taps of the state chain used by the twist and by seeding
    typedef struct packed {
        word_t head;
        word_t second;
        word_t far;
        word_t tail;
    } mtp_taps_t;

    function automatic word_t mix_word(word_t far_word, word_t cur, word_t nxt);
        word_t y;
        word_t r;
        y = (cur & UpperMask) | (nxt & LowerMask);
        r = far_word ^ (y >> 1);
        if (y[0]) begin
            r = r ^ Matrix;
        end
        return r;
    endfunction

    function automatic word_t temper(word_t x);
        word_t y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic word_t init_next(word_t prev, cnt_t idx);
        word_t mixed;
        word_t prod;
        mixed = prev ^ (prev >> 30);
        prod  = InitMult * mixed;
        return prod + {{(32 - CntW){1'b0}}, idx};
    endfunction

endpackage

// ----- rtl/core/mersenne_twister_prng.sv -----
// MT19937 generator top level: control, seeding, twist, tempering and output stage.
//
// Each transfer on the s_ channel requests one word; s_reseed = 1 refills the
// state from the seed register before the draw. Every request returns exactly
// one tempered 32-bit word on the m_ channel, in request order.
// The state lives in a chain of 624 word cells; each draw advances the chain
// by one, twisting the head words (taps 0, 1 and 397) into the tail.
// A plain draw registers its word, which shows in the cycle after the transfer;
// one word per cycle is sustained while m_ready stays high and no seed is needed.
// Seeding fills the chain one word per cycle through the 1812433253 recurrence
// (one 32x32 multiply per cycle) for all 624 words, then the requested word is
// drawn in ST_DRAW; s_ready is low during that run.
// Reset loads seed 5489 and marks the state unseeded; the first request after
// reset seeds. cfg_wr_en writes the seed register, used at the next seeding.
// When the receiver stalls, the word waits in the output register and s_ready
// drops until it is taken.
module mersenne_twister_prng (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  mtp_pkg::word_t  cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_reseed,
    output logic            m_valid,
    input  logic            m_ready,
    output mtp_pkg::word_t  m_random_word
);
    import mtp_pkg::*;

    mtp_state_t state_reg;
    mtp_state_t state_next;
    cnt_t       seed_cnt_reg;
    cnt_t       seed_cnt_next;
    logic       seeded_reg;
    logic       seeded_next;
    word_t      seed_value_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    word_t      m_random_word_reg;

    mtp_taps_t  taps;
    logic       shift_en;
    logic       draw_fire;
    logic       out_free;
    logic       need_seed;
    word_t      twist_word;
    word_t      seed_word;
    word_t      tail_in;

    mtp_chain u_chain (
        .aclk     (aclk),
        .shift_en (shift_en),
        .tail_in  (tail_in),
        .taps     (taps)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign need_seed  = s_reseed || !seeded_reg;
    assign twist_word = mix_word(taps.far, taps.head, taps.second);
    assign seed_word  = (seed_cnt_reg == '0) ? seed_value_reg
                                             : init_next(taps.tail, seed_cnt_reg);

    always_comb begin
        state_next    = state_reg;
        seed_cnt_next = seed_cnt_reg;
        seeded_next   = seeded_reg;
        s_ready       = 1'b0;
        draw_fire     = 1'b0;
        shift_en      = 1'b0;
        tail_in       = twist_word;
        unique case (state_reg)
            ST_RUN: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    if (need_seed) begin
                        state_next = ST_SEED;
                    end else begin
                        draw_fire = 1'b1;
                        shift_en  = 1'b1;
                    end
                end
            end
            ST_SEED: begin
                shift_en = 1'b1;
                tail_in  = seed_word;
                if (seed_cnt_reg == SeedLast) begin
                    seed_cnt_next = '0;
                    seeded_next   = 1'b1;
                    state_next    = ST_DRAW;
                end else begin
                    seed_cnt_next = seed_cnt_reg + cnt_t'(1);
                end
            end
            ST_DRAW: begin
                if (out_free) begin
                    draw_fire  = 1'b1;
                    shift_en   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (draw_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            seed_cnt_reg   <= '0;
            seeded_reg     <= 1'b0;
            seed_value_reg <= SeedReset;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seed_cnt_reg <= seed_cnt_next;
            seeded_reg   <= seeded_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                seed_value_reg <= cfg_wr_data;
            end
        end
    end

    // Output word: temper the freshly twisted word as it enters the tail
    always_ff @(posedge aclk) begin
        if (draw_fire) begin
            m_random_word_reg <= temper(twist_word);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_random_word_reg;

`ifndef NO_ASSERTIONS
    a_seed_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && s_valid && s_ready && need_seed) |=> state_reg == ST_SEED)
        else $error("seeding request did not start a seeding run");

    a_seed_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED && seed_cnt_reg == SeedLast) |=>
            (seeded_reg && state_reg == ST_DRAW))
        else $error("seeding run did not finish into a draw");

    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SEED) |-> seed_cnt_reg == '0)
        else $error("seed counter not cleared outside seeding");

    a_draw_out: assert property (@(posedge aclk) disable iff (!aresetn)
        draw_fire |=> m_valid)
        else $error("draw did not present a word");
`endif

endmodule

// ----- rtl/core/mtp_cell.sv -----
// One 32-bit stage of the state chain: load from the neighbor (or the tail input) on advance.
module mtp_cell (
    input  logic             aclk,
    input  logic             shift_en,
    input  mtp_pkg::word_t   shift_in,
    output mtp_pkg::word_t   word_out
);
    import mtp_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb begin
        data_next = shift_en ? shift_in : data_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign word_out = data_reg;

endmodule

// ----- rtl/core/mtp_chain.sv -----
// Row of state cells forming the 624-word shift line, fed at the tail, with twist and seeding taps.
module mtp_chain (
    input  logic              aclk,
    input  logic              shift_en,
    input  mtp_pkg::word_t    tail_in,
    output mtp_pkg::mtp_taps_t taps
);
    import mtp_pkg::*;

    word_t stage_q [StateWords];

    for (genvar i = 0; i < StateWords; i++) begin : g_cell
        if (i == StateWords - 1) begin : g_tail
            mtp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .shift_in (tail_in),
                .word_out (stage_q[i])
            );
        end else begin : g_body
            mtp_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .shift_in (stage_q[i+1]),
                .word_out (stage_q[i])
            );
        end
    end

    always_comb begin
        taps.head   = stage_q[0];
        taps.second = stage_q[1];
        taps.far    = stage_q[FarTap];
        taps.tail   = stage_q[StateWords-1];
    end

endmodule
